/* design/luhn_pkg.sv */
// Package for the Luhn card number checker: types, constants and divide-by-ten helpers.
package luhn_pkg;

	localparam int IN_W       = 63;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_W      = 12;
	localparam int OUT_TDATA_W = 16;
	localparam int SUM_W      = 8;
	localparam int COUNT_W    = 5;
	localparam int DIGIT_W    = 4;

	// the dividend is walked in 16-bit chunks, one chunk per cycle
	localparam int CHUNK_W    = 16;
	localparam int CHUNKS     = IN_TDATA_W / CHUNK_W;
	localparam int STEP_W     = $clog2(CHUNKS);

	localparam int MAX_DIGITS_DEF = 19;

	localparam logic [COUNT_W-1:0] LEN_MIN = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_MAX = 5'd16;

	localparam logic [DIGIT_W-1:0] LEAD_AMEX       = 4'd3;
	localparam logic [DIGIT_W-1:0] LEAD_VISA       = 4'd4;
	localparam logic [DIGIT_W-1:0] LEAD_MASTERCARD = 4'd5;

	typedef enum logic [1:0] {
		BRAND_NONE       = 2'd0,
		BRAND_AMEX       = 2'd1,
		BRAND_VISA       = 2'd2,
		BRAND_MASTERCARD = 2'd3
	} brand_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_CLASSIFY
	} state_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] quo;
		logic [DIGIT_W-1:0] rem;
	} div10_step_t;

	// One long-division step by ten over a 16-bit chunk, remainder of the chunk above
	// carried in. The dividend stays below 655360, where 419431 / 2^22 is exact.
	function automatic div10_step_t div10_step(input logic [DIGIT_W-1:0] rem_in,
			input logic [CHUNK_W-1:0] chunk);
		logic [19:0]  x;
		logic [38:0]  prod;
		logic [15:0]  q;
		logic [19:0]  diff;
		div10_step_t  res;
		x    = {rem_in, chunk};
		prod = {19'd0, x} * 39'd419431;
		q    = prod[37:22];
		diff = x - ({4'd0, q} * 20'd10);
		res.quo = q;
		res.rem = diff[3:0];
		return res;
	endfunction

	// Remainder of the digit sum by ten; exact for sums below 1029.
	function automatic logic [DIGIT_W-1:0] sum_mod10(input logic [SUM_W-1:0] s);
		logic [18:0]      prod;
		logic [SUM_W-1:0] q;
		logic [SUM_W-1:0] diff;
		prod = {11'd0, s} * 19'd205;
		q    = prod[18:11];
		diff = s - SUM_W'(q * 8'd10);
		return diff[3:0];
	endfunction

endpackage

/* design/luhn_card_number_check.sv */
// Luhn card number checker: iterative decimal digit walk and brand classification.
// Sequence: after the input transfer each of the N decimal digits (at most MAX_DIGITS,
//   none for zero) takes one pass over all chunks, then a classification state loads m_tdata.
// A new item is accepted only in idle, once the last result is loaded into the output; the
//   divide-by-ten unit does one 16-bit chunk per cycle and is shared across all digits.
// Reset (arst_n low) clears the sequencer and the output valid; no result is pending.
module luhn_card_number_check #(
	parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [luhn_pkg::IN_TDATA_W-1:0]    s_tdata,  // [62:0] card_number
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [luhn_pkg::OUT_TDATA_W-1:0]   m_tdata   // [1:0] brand, [2] luhn_ok,
	                                                     // [7:3] digit_count,
	                                                     // [11:8] leading_digit
);

	luhn_pkg::state_t state_q, state_nxt;

	logic [luhn_pkg::IN_TDATA_W-1:0] value_q;
	logic [luhn_pkg::DIGIT_W-1:0]    rem_q;
	logic [luhn_pkg::STEP_W-1:0]     step_q;
	logic [luhn_pkg::SUM_W-1:0]   sum_q;
	logic [luhn_pkg::COUNT_W-1:0] count_q;
	logic [luhn_pkg::DIGIT_W-1:0] lead_q;
	logic                         odd_q;

	logic                           m_valid_q;
	logic [luhn_pkg::OUT_W-1:0]     m_data_q;

	logic                         in_xfer;
	logic                         load_out;
	logic                         last_digit;
	logic                         digit_done;
	luhn_pkg::div10_step_t        dv;
	logic [luhn_pkg::IN_TDATA_W-1:0] quo_next;
	logic [luhn_pkg::COUNT_W-1:0] count_inc;
	logic [4:0]                   dbl;
	logic [luhn_pkg::DIGIT_W-1:0] digit_val;

	logic [luhn_pkg::COUNT_W-1:0] count_fin;
	logic [luhn_pkg::DIGIT_W-1:0] lead_fin;
	logic                         luhn_ok;
	luhn_pkg::brand_t             brand;

	// shared divide-by-ten unit: top chunk in, quotient chunk shifted in at the bottom,
	// so after the last step value holds the full quotient and dv.rem the digit
	assign dv         = luhn_pkg::div10_step(rem_q,
		value_q[luhn_pkg::IN_TDATA_W-1 -: luhn_pkg::CHUNK_W]);
	assign quo_next   = {value_q[luhn_pkg::IN_TDATA_W-luhn_pkg::CHUNK_W-1:0], dv.quo};
	assign digit_done = (step_q == luhn_pkg::STEP_W'(luhn_pkg::CHUNKS - 1));
	assign count_inc  = count_q + 5'd1;
	assign last_digit = digit_done &&
		((quo_next == '0) || (count_inc == luhn_pkg::COUNT_W'(MAX_DIGITS)));

	// every second digit from the right is doubled, two-digit results folded
	always_comb begin
		dbl = {dv.rem, 1'b0};
		if (!odd_q) begin
			digit_val = dv.rem;
		end else if (dbl > 5'd9) begin
			digit_val = luhn_pkg::DIGIT_W'(dbl - 5'd9);
		end else begin
			digit_val = dbl[luhn_pkg::DIGIT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			luhn_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (s_tdata[luhn_pkg::IN_W-1:0] == '0) begin
						state_nxt = luhn_pkg::ST_CLASSIFY;
					end else begin
						state_nxt = luhn_pkg::ST_DIGIT;
					end
				end
			end
			luhn_pkg::ST_DIGIT: begin
				if (last_digit) begin
					state_nxt = luhn_pkg::ST_CLASSIFY;
				end
			end
			luhn_pkg::ST_CLASSIFY: begin
				if (load_out) begin
					state_nxt = luhn_pkg::ST_IDLE;
				end
			end
			default: state_nxt = luhn_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == luhn_pkg::ST_IDLE);
		load_out = (state_q == luhn_pkg::ST_CLASSIFY) && (!m_valid_q || m_tready);
	end

	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= luhn_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// digit walk datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q <= {1'b0, s_tdata[luhn_pkg::IN_W-1:0]};
			rem_q   <= '0;
			step_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			lead_q  <= '0;
			odd_q   <= 1'b0;
		end else if (state_q == luhn_pkg::ST_DIGIT) begin
			value_q <= quo_next;
			step_q  <= step_q + luhn_pkg::STEP_W'(1);
			if (digit_done) begin
				rem_q   <= '0;
				sum_q   <= sum_q + luhn_pkg::SUM_W'(digit_val);
				count_q <= count_inc;
				lead_q  <= dv.rem;
				odd_q   <= ~odd_q;
			end else begin
				rem_q   <= dv.rem;
			end
		end
	end

	// classification; zero counts as the single digit 0
	always_comb begin
		count_fin = (count_q == '0) ? 5'd1 : count_q;
		lead_fin  = (count_q == '0) ? '0 : lead_q;
		luhn_ok   = (luhn_pkg::sum_mod10(sum_q) == '0);
		brand     = luhn_pkg::BRAND_NONE;
		if (luhn_ok && (count_fin >= luhn_pkg::LEN_MIN) && (count_fin <= luhn_pkg::LEN_MAX)) begin
			priority if (lead_fin == luhn_pkg::LEAD_AMEX) begin
				brand = luhn_pkg::BRAND_AMEX;
			end else if (lead_fin == luhn_pkg::LEAD_VISA) begin
				brand = luhn_pkg::BRAND_VISA;
			end else if (lead_fin == luhn_pkg::LEAD_MASTERCARD) begin
				brand = luhn_pkg::BRAND_MASTERCARD;
			end else begin
				brand = luhn_pkg::BRAND_NONE;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {lead_fin, count_fin, luhn_ok, brand};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(luhn_pkg::OUT_TDATA_W - luhn_pkg::OUT_W){1'b0}}, m_data_q};

endmodule
